/* src/tcba_pkg.sv */
// tcba_pkg: sizes, codes, status type and memory port structs for the threshold change
// and block average design; no dependencies, imported by every other file
`default_nettype none

package tcba_pkg;

   // block sizing
   localparam int WINDOW      = 10;
   localparam int SLOTS       = 6;
   localparam int INTERVALS   = 60;
   localparam int SAMPLE_BITS = 16;

   // fixed field widths of the channels
   localparam int IN_VALUE_BITS = 16;
   localparam int THR_BITS      = 16;
   localparam int AVG_OUT_BITS  = 16;
   localparam int SLOT_OUT_BITS = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;

   // derived widths
   localparam int POS_BITS      = $clog2(WINDOW);
   localparam int SLOT_IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS      = $clog2(INTERVALS);
   localparam int WIN_BITS      = $clog2(INTERVALS / WINDOW + 2);
   localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW);

   // divide by WINDOW as multiply by rounded-up reciprocal, exact for any SUM_BITS value
   localparam int DIV_SHIFT  = SUM_BITS + $clog2(WINDOW);
   localparam int MULT_BITS  = SUM_BITS + 1;
   localparam int PROD_BITS  = SUM_BITS + MULT_BITS;
   localparam logic [MULT_BITS-1:0] DIV_MULT =
      MULT_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   localparam logic [31:0] BIG_LIMIT = 32'd32767;

   // reset values of the thresholds
   localparam logic [THR_BITS-1:0] OPEN_RESET  = THR_BITS'(28);
   localparam logic [THR_BITS-1:0] CLOSE_RESET = THR_BITS'(20);

   // codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_READOUT = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_OPEN  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_CLOSE = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_ON   = 2'd1,
      ST_OFF  = 2'd2
   } status_type;

   // ring memory ports
   typedef struct packed {
      logic                en;
      logic [POS_BITS-1:0] addr_a;
      logic [POS_BITS-1:0] addr_b;
   } ring_rd_type;

   typedef struct packed {
      logic                   en;
      logic [POS_BITS-1:0]    addr;
      logic [SAMPLE_BITS-1:0] data;
   } ring_wr_type;

   // average slot memory ports
   typedef struct packed {
      logic                     en;
      logic [SLOT_IDX_BITS-1:0] addr;
   } slot_rd_type;

   typedef struct packed {
      logic                     en;
      logic [SLOT_IDX_BITS-1:0] addr;
      logic [SUM_BITS-1:0]      data;
   } slot_wr_type;

endpackage

`default_nettype wire

/* src/tcba_if.sv */
// tcba channel interfaces: sample/drain request, result and register write channels
// depends on tcba_pkg for field widths and the status type
`default_nettype none

interface tcba_req_if import tcba_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [IN_VALUE_BITS-1:0] sample_value;

   modport source (output valid, output opcode, output sample_value, input ready);
   modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface tcba_rsp_if import tcba_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     report_kind;
   status_type               pump_status;
   logic                     status_change;
   logic                     report_due;
   logic                     average_ready;
   logic [AVG_OUT_BITS-1:0]  average_value;
   logic [SLOT_OUT_BITS-1:0] slot_index;
   logic                     too_large;
   logic                     last;

   modport source (output valid, output report_kind, output pump_status,
                   output status_change, output report_due, output average_ready,
                   output average_value, output slot_index, output too_large,
                   output last, input ready);
   modport sink   (input valid, input report_kind, input pump_status,
                   input status_change, input report_due, input average_ready,
                   input average_value, input slot_index, input too_large,
                   input last, output ready);
endinterface

interface tcba_csr_if import tcba_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/tcba_ring.sv */
// tcba_ring: sample ring memory, one write port and two registered read ports
// entries read as zero until first written; depends on tcba_pkg
`default_nettype none

module tcba_ring import tcba_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ring_rd_type            rd,
   input  ring_wr_type            wr,
   output logic [SAMPLE_BITS-1:0] rd_a_ff,
   output logic [SAMPLE_BITS-1:0] rd_b_ff
);

   logic [SAMPLE_BITS-1:0] mem_ff [WINDOW];
   logic [WINDOW-1:0]      valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_a_ff <= valid_ff[rd.addr_a] ? mem_ff[rd.addr_a] : '0;
         rd_b_ff <= valid_ff[rd.addr_b] ? mem_ff[rd.addr_b] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

endmodule

`default_nettype wire

/* src/tcba_slots.sv */
// tcba_slots: average slot memory holding window sums, read with clear-on-read
// one write port, one registered read port; depends on tcba_pkg
`default_nettype none

module tcba_slots import tcba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  slot_rd_type         rd,
   input  slot_wr_type         wr,
   output logic [SUM_BITS-1:0] rd_ff
);

   logic [SUM_BITS-1:0] mem_ff [SLOTS];
   logic [SLOTS-1:0]    valid_ff;
   logic [SLOTS-1:0]    valid_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_ff <= valid_ff[rd.addr] ? mem_ff[rd.addr] : '0;
      end
   end

   // read clears the entry; a read is always younger than a write in the same cycle
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
      if (rd.en) begin
         valid_in[rd.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

/* src/tcba_div.sv */
// tcba_div: window sum divided by the window length via reciprocal multiply
// depends on tcba_pkg for the multiplier constant and shift
`default_nettype none

module tcba_div import tcba_pkg::*; (
   input  logic [SUM_BITS-1:0]    sum,
   output logic [SAMPLE_BITS-1:0] quot
);

   logic [PROD_BITS-1:0] product;

   assign product = PROD_BITS'(sum) * PROD_BITS'(DIV_MULT);
   assign quot    = SAMPLE_BITS'(product >> DIV_SHIFT);

endmodule

`default_nettype wire

/* src/threshold_change_and_block_average.sv */
// threshold_change_and_block_average: top level with sequencing, forwarding and output stage
// depends on tcba_pkg, tcba_if, tcba_ring, tcba_slots and tcba_div
//
// Sorts each sample beat into on / off / no status against two programmable thresholds,
// flags a status change against the previous ring entry, keeps a running window sum over
// the last WINDOW samples and, at the end of every window, stores that sum in one of SLOTS
// average slots (the mean is formed when results leave). After INTERVALS samples the
// counters wrap and a sticky report-due flag is set. A drain beat reads out every slot
// in order, clears them and clears the flag. Sample beats are taken one per cycle unless
// rsp_port stalls; a drain beat likewise produces SLOTS result beats, one per cycle, and
// req_port.ready stays low until its last slot beat has entered, as the slot memory has a
// single read port. A result passes the ring read into stage b, the sum update into stage c
// and the divide into the output register; while it waits on rsp_port, the two stages b and
// c still take up to two more request beats before req_port.ready drops. Register writes on
// csr_port are always ready and are meant to happen only with the block idle.
`default_nettype none

module threshold_change_and_block_average import tcba_pkg::*; (
   input logic        clock,
   input logic        reset,
   tcba_req_if.sink   req_port,
   tcba_rsp_if.source rsp_port,
   tcba_csr_if.sink   csr_port
);

   function automatic status_type classify(input logic [SAMPLE_BITS-1:0] v,
                                           input logic [THR_BITS-1:0]    open_thr,
                                           input logic [THR_BITS-1:0]    close_thr);
      status_type st;
      if (32'(v) > 32'(open_thr)) begin
         st = ST_ON;
      end else if (32'(v) < 32'(close_thr)) begin
         st = ST_OFF;
      end else begin
         st = ST_NONE;
      end
      return st;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [THR_BITS-1:0] open_thr_ff;
   logic [THR_BITS-1:0] close_thr_ff;

   // sequencing state, advanced when a beat enters the pipeline
   logic [CNT_BITS-1:0]      cnt_ff,        cnt_in;
   logic [POS_BITS-1:0]      pos_ff,        pos_in;
   logic [WIN_BITS-1:0]      win_ff,        win_in;
   logic                     due_ff,        due_in;
   logic                     drain_busy_ff, drain_busy_in;
   logic [SLOT_IDX_BITS-1:0] drain_idx_ff,  drain_idx_in;
   logic                     drain_due_ff,  drain_due_in;

   // stage b: memory data arrives, running sum updated, memories written
   logic                     b_v_ff;
   logic                     b_kind_ff;
   logic [SAMPLE_BITS-1:0]   b_val_ff;
   logic [POS_BITS-1:0]      b_pos_ff;
   status_type               b_cur_ff;
   logic                     b_rdy_ff;
   logic [SLOT_IDX_BITS-1:0] b_slot_ff;
   logic                     b_due_ff;
   logic                     b_last_ff;
   logic                     b_hit_old_ff;
   logic                     b_hit_prev_ff;
   logic [SAMPLE_BITS-1:0]   b_ring_fwd_ff;
   logic                     b_hit_slot_ff;
   logic [SUM_BITS-1:0]      b_slot_fwd_ff;

   logic [SUM_BITS-1:0]      sum_ff;

   // stage c: divide
   logic                     c_v_ff;
   logic                     c_kind_ff;
   status_type               c_status_ff;
   logic                     c_chg_ff;
   logic                     c_due_ff;
   logic                     c_rdy_ff;
   logic [SUM_BITS-1:0]      c_sum_ff;
   logic [SLOT_IDX_BITS-1:0] c_slot_ff;
   logic                     c_last_ff;

   // output register
   logic                     out_v_ff;
   logic                     out_kind_ff;
   status_type               out_status_ff;
   logic                     out_chg_ff;
   logic                     out_due_ff;
   logic                     out_rdy_ff;
   logic [AVG_OUT_BITS-1:0]  out_avg_ff;
   logic [SLOT_OUT_BITS-1:0] out_slot_ff;
   logic                     out_big_ff;
   logic                     out_last_ff;

   // memory read data
   logic [SAMPLE_BITS-1:0]   ring_old_ff;
   logic [SAMPLE_BITS-1:0]   ring_prev_ff;
   logic [SUM_BITS-1:0]      slot_rd_ff;

   // ---------------------------------------------------------------- flow control
   logic out_free;
   logic c_en;
   logic b_en;
   logic a_go;
   logic req_fire;

   assign out_free = !out_v_ff || rsp_port.ready;
   assign c_en     = !c_v_ff || out_free;
   assign b_en     = !b_v_ff || c_en;

   // a drain in progress owns the entry stage until its last slot beat
   assign req_port.ready = b_en && !drain_busy_ff;
   assign req_fire       = req_port.valid && req_port.ready;
   assign a_go           = b_en && (drain_busy_ff || req_port.valid);

   // ---------------------------------------------------------------- config
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_thr_ff  <= OPEN_RESET;
         close_thr_ff <= CLOSE_RESET;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            REG_OPEN: begin
               open_thr_ff <= THR_BITS'(csr_port.data);
            end
            REG_CLOSE: begin
               close_thr_ff <= THR_BITS'(csr_port.data);
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- entry stage
   logic                     a_is_drain;
   logic [SLOT_IDX_BITS-1:0] a_drain_idx;
   logic                     a_drain_due;
   logic                     a_drain_last;
   logic [SAMPLE_BITS-1:0]   a_val;
   logic [POS_BITS-1:0]      a_prev_pos;
   logic                     a_end;
   logic                     a_slot_ok;
   logic                     a_rdy;
   logic [SLOT_IDX_BITS-1:0] a_slot;
   logic                     a_wrap;
   status_type               a_cur;
   logic                     a_hit_old;
   logic                     a_hit_prev;
   logic                     a_hit_slot;
   logic                     b_is_sample;
   logic [SUM_BITS-1:0]      b_new_sum;

   assign a_is_drain   = drain_busy_ff || (req_port.opcode == OP_DRAIN);
   assign a_drain_idx  = drain_busy_ff ? drain_idx_ff : '0;
   assign a_drain_due  = drain_busy_ff ? drain_due_ff : due_ff;
   assign a_drain_last = a_drain_idx == SLOT_IDX_BITS'(SLOTS - 1);

   assign a_val      = SAMPLE_BITS'(req_port.sample_value);
   assign a_prev_pos = (pos_ff == '0) ? POS_BITS'(WINDOW - 1) : pos_ff - 1'b1;
   assign a_end      = pos_ff == POS_BITS'(WINDOW - 1);
   assign a_slot_ok  = 32'(win_ff) < SLOTS;
   assign a_rdy      = a_end && a_slot_ok;
   assign a_slot     = SLOT_IDX_BITS'(win_ff);
   assign a_wrap     = cnt_ff == CNT_BITS'(INTERVALS - 1);
   assign a_cur      = classify(a_val, open_thr_ff, close_thr_ff);

   // the beat in stage b writes its entry on the same edge these reads are taken,
   // so its data is forwarded instead of the stale memory word
   assign b_is_sample = b_kind_ff == KIND_SAMPLE;
   assign a_hit_old   = b_v_ff && b_is_sample && (b_pos_ff == pos_ff);
   assign a_hit_prev  = b_v_ff && b_is_sample && (b_pos_ff == a_prev_pos);
   assign a_hit_slot  = b_v_ff && b_is_sample && b_rdy_ff && (b_slot_ff == a_drain_idx);

   always_comb begin
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      win_in        = win_ff;
      due_in        = due_ff;
      drain_busy_in = drain_busy_ff;
      drain_idx_in  = drain_idx_ff;
      drain_due_in  = drain_due_ff;
      if (a_go) begin
         if (a_is_drain) begin
            if (!drain_busy_ff) begin
               // first slot beat: latch the flag for the later beats, then clear it
               drain_due_in = due_ff;
               due_in       = 1'b0;
            end
            if (a_drain_last) begin
               drain_busy_in = 1'b0;
               drain_idx_in  = '0;
            end else begin
               drain_busy_in = 1'b1;
               drain_idx_in  = a_drain_idx + 1'b1;
            end
         end else if (a_wrap) begin
            cnt_in = '0;
            pos_in = '0;
            win_in = '0;
            due_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            pos_in = a_end ? '0 : pos_ff + 1'b1;
            win_in = a_end ? win_ff + 1'b1 : win_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         pos_ff        <= '0;
         win_ff        <= '0;
         due_ff        <= 1'b0;
         drain_busy_ff <= 1'b0;
         drain_idx_ff  <= '0;
         drain_due_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         pos_ff        <= pos_in;
         win_ff        <= win_in;
         due_ff        <= due_in;
         drain_busy_ff <= drain_busy_in;
         drain_idx_ff  <= drain_idx_in;
         drain_due_ff  <= drain_due_in;
      end
   end

   // ---------------------------------------------------------------- memories
   ring_rd_type ring_rd;
   ring_wr_type ring_wr;
   slot_rd_type slot_rd;
   slot_wr_type slot_wr;
   logic        b_adv;

   assign b_adv = b_v_ff && c_en;

   assign ring_rd.en     = a_go && !a_is_drain;
   assign ring_rd.addr_a = pos_ff;
   assign ring_rd.addr_b = a_prev_pos;

   assign ring_wr.en   = b_adv && b_is_sample;
   assign ring_wr.addr = b_pos_ff;
   assign ring_wr.data = b_val_ff;

   assign slot_rd.en   = a_go && a_is_drain;
   assign slot_rd.addr = a_drain_idx;

   assign slot_wr.en   = b_adv && b_is_sample && b_rdy_ff;
   assign slot_wr.addr = b_slot_ff;
   assign slot_wr.data = b_new_sum;

   tcba_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd      (ring_rd),
      .wr      (ring_wr),
      .rd_a_ff (ring_old_ff),
      .rd_b_ff (ring_prev_ff)
   );

   tcba_slots u_slots (
      .clock (clock),
      .reset (reset),
      .rd    (slot_rd),
      .wr    (slot_wr),
      .rd_ff (slot_rd_ff)
   );

   // ---------------------------------------------------------------- stage b
   logic [SAMPLE_BITS-1:0] b_old;
   logic [SAMPLE_BITS-1:0] b_prev;
   status_type             b_prev_st;
   logic                   b_chg;
   logic [SUM_BITS-1:0]    b_c_sum;

   assign b_old     = b_hit_old_ff  ? b_ring_fwd_ff : ring_old_ff;
   assign b_prev    = b_hit_prev_ff ? b_ring_fwd_ff : ring_prev_ff;
   // the running sum always covers the entry being replaced, so no underflow
   assign b_new_sum = sum_ff - SUM_BITS'(b_old) + SUM_BITS'(b_val_ff);
   assign b_prev_st = classify(b_prev, open_thr_ff, close_thr_ff);
   assign b_chg     = (b_cur_ff != b_prev_st) && (b_cur_ff != ST_NONE);

   always_comb begin
      if (b_is_sample) begin
         b_c_sum = b_rdy_ff ? b_new_sum : '0;
      end else begin
         b_c_sum = b_hit_slot_ff ? b_slot_fwd_ff : slot_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en && a_go) begin
         b_kind_ff     <= a_is_drain ? KIND_READOUT : KIND_SAMPLE;
         b_val_ff      <= a_val;
         b_pos_ff      <= pos_ff;
         b_cur_ff      <= a_cur;
         b_rdy_ff      <= !a_is_drain && a_rdy;
         b_slot_ff     <= a_is_drain ? a_drain_idx : (a_rdy ? a_slot : '0);
         b_due_ff      <= a_is_drain ? a_drain_due : (due_ff || a_wrap);
         b_last_ff     <= a_is_drain ? a_drain_last : 1'b1;
         b_hit_old_ff  <= a_hit_old;
         b_hit_prev_ff <= a_hit_prev;
         b_ring_fwd_ff <= b_val_ff;
         b_hit_slot_ff <= a_hit_slot;
         b_slot_fwd_ff <= b_new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (b_adv && b_is_sample) begin
         sum_ff <= b_new_sum;
      end
   end

   // ---------------------------------------------------------------- stage c
   logic [SAMPLE_BITS-1:0] c_avg;
   logic                   c_big;

   tcba_div u_div (
      .sum  (c_sum_ff),
      .quot (c_avg)
   );

   assign c_big = (c_kind_ff == KIND_READOUT) && (32'(c_avg) > BIG_LIMIT);

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_kind_ff   <= b_kind_ff;
         c_status_ff <= b_is_sample ? b_cur_ff : ST_NONE;
         c_chg_ff    <= b_is_sample && b_chg;
         c_due_ff    <= b_due_ff;
         c_rdy_ff    <= b_rdy_ff;
         c_sum_ff    <= b_c_sum;
         c_slot_ff   <= b_slot_ff;
         c_last_ff   <= b_last_ff;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (out_free && c_v_ff) begin
         out_kind_ff   <= c_kind_ff;
         out_status_ff <= c_status_ff;
         out_chg_ff    <= c_chg_ff;
         out_due_ff    <= c_due_ff;
         out_rdy_ff    <= c_rdy_ff;
         out_avg_ff    <= AVG_OUT_BITS'(c_avg);
         out_slot_ff   <= SLOT_OUT_BITS'(c_slot_ff);
         out_big_ff    <= c_big;
         out_last_ff   <= c_last_ff;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (b_en) begin
            b_v_ff <= a_go;
         end
         if (c_en) begin
            c_v_ff <= b_v_ff;
         end
         if (out_free) begin
            out_v_ff <= c_v_ff;
         end
      end
   end

   assign rsp_port.valid         = out_v_ff;
   assign rsp_port.report_kind   = out_kind_ff;
   assign rsp_port.pump_status   = out_status_ff;
   assign rsp_port.status_change = out_chg_ff;
   assign rsp_port.report_due    = out_due_ff;
   assign rsp_port.average_ready = out_rdy_ff;
   assign rsp_port.average_value = out_avg_ff;
   assign rsp_port.slot_index    = out_slot_ff;
   assign rsp_port.too_large     = out_big_ff;
   assign rsp_port.last          = out_last_ff;

endmodule

`default_nettype wire

/* tb/tcba_tb_pkg.sv */
// result beat type and status tracker for the threshold change and block average testbench
// depends on tcba_pkg for sizes, codes and the status type
package tcba_tb_pkg;
   import tcba_pkg::*;

   typedef struct {
      logic                     kind;
      status_type               status;
      logic                     change;
      logic                     due;
      logic                     avg_ready;
      logic [AVG_OUT_BITS-1:0]  avg;
      logic [SLOT_OUT_BITS-1:0] slot;
      logic                     big;
      logic                     last;
   } report_beat_type;

   // tracks thresholds, ring, window sum, counter, slots and due flag; queues the
   // report beats each request beat should produce and checks arriving ones in order
   class pump_report_tracker;
      logic [THR_BITS-1:0]     open_thr;
      logic [THR_BITS-1:0]     close_thr;
      logic [SAMPLE_BITS-1:0]  ring [WINDOW];
      logic [AVG_OUT_BITS-1:0] slots [SLOTS];
      int unsigned             win_sum;
      int unsigned             sample_cnt;
      logic                    due;
      report_beat_type         expected_reports [$];
      int unsigned             beat_no;
      int                      errors;

      function new();
         open_thr   = OPEN_RESET;
         close_thr  = CLOSE_RESET;
         win_sum    = 0;
         sample_cnt = 0;
         due        = 1'b0;
         beat_no    = 0;
         errors     = 0;
         foreach (ring[i]) ring[i] = '0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function void set_threshold(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
         if (idx == REG_OPEN) begin
            open_thr = value;
         end else begin
            close_thr = value;
         end
      endfunction

      // on is tested first, so a value past both thresholds is on
      function status_type grade(logic [SAMPLE_BITS-1:0] value);
         if (value > open_thr) begin
            return ST_ON;
         end
         if (value < close_thr) begin
            return ST_OFF;
         end
         return ST_NONE;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void predict_beat(logic op, logic [IN_VALUE_BITS-1:0] value);
         report_beat_type r;
         int unsigned     cnt;
         int unsigned     pos;
         int unsigned     prev_pos;
         int unsigned     s;
         status_type      prev_st;
         if (op == OP_DRAIN) begin
            for (int i = 0; i < SLOTS; i++) begin
               r.kind      = KIND_READOUT;
               r.status    = ST_NONE;
               r.change    = 1'b0;
               r.due       = due;
               r.avg_ready = 1'b0;
               r.avg       = slots[i];
               r.slot      = SLOT_OUT_BITS'(i);
               r.big       = (slots[i] > BIG_LIMIT);
               r.last      = (i == SLOTS - 1);
               expected_reports.push_back(r);
               slots[i] = '0;
            end
            due = 1'b0;
            return;
         end
         cnt      = sample_cnt + 1;
         pos      = (cnt - 1) % WINDOW;
         prev_pos = (pos == 0) ? WINDOW - 1 : pos - 1;
         win_sum  = win_sum + value - ring[pos];
         ring[pos] = value;
         r.kind      = KIND_SAMPLE;
         r.status    = grade(value);
         prev_st     = grade(ring[prev_pos]);
         r.change    = (r.status != prev_st) && (r.status != ST_NONE);
         r.avg_ready = 1'b0;
         r.avg       = '0;
         r.slot      = '0;
         r.big       = 1'b0;
         r.last      = 1'b1;
         if (cnt % WINDOW == 0) begin
            s = cnt / WINDOW - 1;
            if (s < SLOTS) begin
               r.avg       = AVG_OUT_BITS'(win_sum / WINDOW);
               r.slot      = SLOT_OUT_BITS'(s);
               r.avg_ready = 1'b1;
               slots[s]    = r.avg;
            end
         end
         if (cnt >= INTERVALS) begin
            due = 1'b1;
            cnt = 0;
         end
         sample_cnt = cnt;
         r.due = due;
         expected_reports.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result beat %0d %s: got %0h, expected %0h",
                                      beat_no, name, got, want));
         end
      endtask

      task compare_report(report_beat_type got);
         report_beat_type want;
         beat_no++;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("result beat %0d arrived with nothing expected", beat_no));
            return;
         end
         want = expected_reports.pop_front();
         check_field("report_kind", got.kind, want.kind);
         check_field("pump_status", got.status, want.status);
         check_field("status_change", got.change, want.change);
         check_field("report_due", got.due, want.due);
         check_field("average_ready", got.avg_ready, want.avg_ready);
         check_field("average_value", got.avg, want.avg);
         check_field("slot_index", got.slot, want.slot);
         check_field("too_large", got.big, want.big);
         check_field("last", got.last, want.last);
      endtask
   endclass

endpackage

/* tb/tb.sv */
// top testbench for threshold_change_and_block_average: drives sample, drain and register
// beats with random pacing and checks every result beat against pump_report_tracker
// depends on tcba_pkg, tcba_if, tcba_tb_pkg and the block's RTL
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcba_pkg::*;
   import tcba_tb_pkg::*;

   // value shapes used for the random sample runs
   typedef enum int {
      VAL_NEAR_THR,
      VAL_ANY,
      VAL_HIGH,
      VAL_MIDPOINT,
      VAL_EXTREME
   } value_shape_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 16;   // lets the pipeline empty after the last beat

   logic clock;
   logic reset;

   tcba_req_if req_bus ();
   tcba_rsp_if rsp_bus ();
   tcba_csr_if csr_bus ();

   threshold_change_and_block_average DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   pump_report_tracker tracker;

   int unsigned cycle_count;
   bit          req_calm;   // while set, request beats go back to back
   bit          rsp_calm;   // while set, ready is held high

   // clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // every input known from time zero
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_SAMPLE;
      req_bus.sample_value = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = REG_OPEN;
      csr_bus.data         = '0;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // draws the idle cycles before one beat, with calm stretches of no idling
   function automatic int draw_gap(ref bit calm);
      if ($urandom_range(0, 19) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   // one request beat: idle with junk payload, then hold valid until the handshake
   task automatic send_beat(input logic op, input logic [IN_VALUE_BITS-1:0] value);
      int gap;
      gap = draw_gap(req_calm);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid        <= 1'b0;
         req_bus.opcode       <= 1'($urandom);
         req_bus.sample_value <= IN_VALUE_BITS'($urandom);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.sample_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      tracker.predict_beat(op, value);
   endtask

   // result side: random stalls on ready, every accepted beat goes to the tracker
   task automatic take_results();
      int              stall;
      report_beat_type got;
      forever begin
         stall = draw_gap(rsp_calm);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.kind      = rsp_bus.report_kind;
         got.status    = rsp_bus.pump_status;
         got.change    = rsp_bus.status_change;
         got.due       = rsp_bus.report_due;
         got.avg_ready = rsp_bus.average_ready;
         got.avg       = rsp_bus.average_value;
         got.slot      = rsp_bus.slot_index;
         got.big       = rsp_bus.too_large;
         got.last      = rsp_bus.last;
         tracker.compare_report(got);
      end
   endtask

   // drop valid, let every expected beat come back, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.set_threshold(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [IN_VALUE_BITS-1:0] pick_value(value_shape_type shape);
      int base;
      case (shape)
         VAL_NEAR_THR: begin
            // straddle whichever threshold, to make status flips frequent
            base = $urandom_range(0, 1) ? int'(tracker.open_thr) : int'(tracker.close_thr);
            base = base + int'($urandom_range(0, 4)) - 2;
            if (base < 0) base = 0;
            if (base > 65535) base = 65535;
            return IN_VALUE_BITS'(base);
         end
         VAL_HIGH:     return IN_VALUE_BITS'($urandom_range(32768, 65535));
         VAL_MIDPOINT: return IN_VALUE_BITS'($urandom_range(32764, 32771));
         VAL_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return 16'h0000;
               1:       return 16'h0001;
               2:       return 16'hFFFE;
               default: return 16'hFFFF;
            endcase
         end
         default:      return IN_VALUE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // one threshold setting, then runs of samples each closed by a drain beat;
   // most runs cover a full interval so all slots fill and the due flag sets
   task automatic run_phase(input logic [THR_BITS-1:0] open_val,
                            input logic [THR_BITS-1:0] close_val,
                            input int n_items);
      int              done;
      int              run_len;
      value_shape_type shape;
      wait_idle();
      if ($urandom_range(0, 1)) begin
         write_reg(REG_OPEN, open_val);
         write_reg(REG_CLOSE, close_val);
      end else begin
         write_reg(REG_CLOSE, close_val);
         write_reg(REG_OPEN, open_val);
      end
      done = 0;
      while (done < n_items) begin
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(55, 70);
         shape   = value_shape_type'($urandom_range(0, 4));
         for (int i = 0; i < run_len; i++) begin
            // a stray drain now and then, mid-window
            if ($urandom_range(0, 40) == 0) begin
               send_beat(OP_DRAIN, IN_VALUE_BITS'($urandom));
            end
            if ($urandom_range(0, 7) == 0) begin
               shape = value_shape_type'($urandom_range(0, 4));
            end
            send_beat(OP_SAMPLE, pick_value(shape));
         end
         send_beat(OP_DRAIN, IN_VALUE_BITS'($urandom));
         done = done + run_len + 1;
      end
   endtask

   initial begin
      logic [THR_BITS-1:0] open_val;
      logic [THR_BITS-1:0] close_val;
      tracker  = new();
      req_calm = 1'b0;
      rsp_calm = 1'b0;

      // synchronous reset, released on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fork
         take_results();
      join_none

      // directed part, reset thresholds open 28 / close 20
      send_beat(OP_DRAIN, 16'hFFFF);        // drain right after reset: zero slots, flag clear
      send_beat(OP_SAMPLE, 16'd0);          // first sample: previous entry is a reset zero
      send_beat(OP_SAMPLE, 16'd20);         // equal to close: no status
      send_beat(OP_SAMPLE, 16'd19);         // just below close: off, change
      send_beat(OP_SAMPLE, 16'd28);         // equal to open: no status
      send_beat(OP_SAMPLE, 16'd29);         // just above open: on, change
      send_beat(OP_SAMPLE, 16'hFFFF);       // on again, no change
      send_beat(OP_SAMPLE, 16'd21);
      send_beat(OP_SAMPLE, 16'd27);
      send_beat(OP_SAMPLE, 16'd0);          // off after none
      send_beat(OP_SAMPLE, 16'd1);          // tenth sample closes the first window
      send_beat(OP_DRAIN, 16'h0000);        // slot 0 holds that mean
      send_beat(OP_SAMPLE, 16'h8000);       // ring position 0: previous entry wraps to the end
      send_beat(OP_SAMPLE, 16'hFFFE);
      send_beat(OP_SAMPLE, 16'h5555);
      send_beat(OP_SAMPLE, 16'hAAAA);
      send_beat(OP_SAMPLE, 16'd27);

      // threshold extremes, including both tests passing at once
      run_phase(16'h0000, 16'h0000, 55);
      run_phase(16'hFFFF, 16'hFFFF, 55);
      run_phase(16'h0000, 16'hFFFF, 55);
      run_phase(16'hFFFF, 16'h0000, 55);

      // random settings, some with a narrow band between the thresholds
      repeat (4) begin
         open_val = THR_BITS'($urandom_range(0, 65535));
         if ($urandom_range(0, 1)) begin
            close_val = THR_BITS'($urandom_range(0, 65535));
         end else begin
            close_val = (open_val > 10) ? open_val - THR_BITS'($urandom_range(0, 10)) : open_val;
         end
         run_phase(open_val, close_val, 55);
      end

      // drain everything outstanding, then allow for any late beat
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
